FILE: src/cg2_pkg.sv
// cg2_pkg: shared types, constants and tables for the correlated 2D Gaussian unit.
// Used by every cell, the combine stage and the top level. No dependencies.
`timescale 1ns / 1ps

package cg2_pkg;

   // Step counts of the cell chains
   localparam int LOG_STEPS    = 24;
   localparam int SQRT_STEPS   = 32;
   localparam int CORDIC_STEPS = 30;

   // Pipeline layout (cycles from the input transfer)
   localparam int RADIUS_LAT  = 1 + LOG_STEPS + 1 + SQRT_STEPS;
   localparam int ANGLE_LAT   = 1 + CORDIC_STEPS + 1;
   localparam int ROOT_LAT    = 1 + SQRT_STEPS;
   localparam int ANGLE_DLY   = RADIUS_LAT - ANGLE_LAT;
   localparam int ROOT_DLY    = RADIUS_LAT - ROOT_LAT;
   localparam int COMB_STAGES = 5;
   localparam int PIPE_DEPTH  = RADIUS_LAT + COMB_STAGES;

   // Status codes
   localparam logic [1:0] STATUS_OK   = 2'd0;
   localparam logic [1:0] STATUS_RHO  = 2'd1;
   localparam logic [1:0] STATUS_ZERO = 2'd2;

   // Register indexes
   localparam logic [2:0] REG_MEAN_X  = 3'd0;
   localparam logic [2:0] REG_MEAN_Y  = 3'd1;
   localparam logic [2:0] REG_SIGMA_X = 3'd2;
   localparam logic [2:0] REG_SIGMA_Y = 3'd3;
   localparam logic [2:0] REG_RHO     = 3'd4;

   // Arithmetic constants
   localparam logic [31:0]        LN2_Q32     = 32'hB172_17F8;
   localparam logic signed [33:0] CORDIC_K    = 34'sh0_26DD_3B6A;
   localparam logic signed [33:0] QUARTER     = 34'sh0_4000_0000;
   localparam logic signed [33:0] HALF_TURN   = 34'sh0_8000_0000;
   localparam logic [29:0]        LOG_SPAN    = 30'(32) << LOG_STEPS;
   localparam logic [31:0]        ONE_Q30     = 32'h4000_0000;
   localparam logic signed [15:0] RHO_MINUS1  = 16'sh8000;

   // atan(2^-i) in turns, Q.32
   localparam logic [31:0] ATAN_TURNS [CORDIC_STEPS] = '{
      32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
      32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
      32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2F9,
      32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
      32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
      32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001
   };

   // Log2 chain payload
   typedef struct packed {
      logic [4:0]  k;
      logic [31:0] m;
      logic [LOG_STEPS-1:0] frac;
   } log_type;

   // Square root chain payload
   typedef struct packed {
      logic [63:0] n;
      logic [63:0] res;
   } sqrt_type;

   // CORDIC chain payload
   typedef struct packed {
      logic signed [33:0] x;
      logic signed [33:0] y;
      logic signed [33:0] z;
      logic               neg;
   } cordic_type;

   // Configuration registers
   typedef struct packed {
      logic signed [31:0] mean_x;
      logic signed [31:0] mean_y;
      logic [31:0]        sigma_x;
      logic [31:0]        sigma_y;
      logic signed [15:0] rho;
   } cfg_type;

   // One result
   typedef struct packed {
      logic signed [31:0] x_out;
      logic signed [31:0] y_out;
      logic [1:0]         status;
   } result_type;

endpackage

FILE: src/cg2_log_cell.sv
// cg2_log_cell: one fraction bit of log2 by squaring the normalized mantissa.
// Depends on cg2_pkg.
`timescale 1ns / 1ps

module cg2_log_cell (
   input  logic             clock,
   input  logic             en,
   input  cg2_pkg::log_type d_in,
   output cg2_pkg::log_type d_out
);

   cg2_pkg::log_type d_ff, d_in_v;
   logic [63:0] sq;
   logic [32:0] p;

   // Square, keep Q1.31, renormalize when it reaches two
   always_comb begin
      sq = 64'(d_in.m) * 64'(d_in.m);
      p  = sq[63:31];
      d_in_v.k = d_in.k;
      if (p[32]) begin
         d_in_v.m    = p[32:1];
         d_in_v.frac = {d_in.frac[cg2_pkg::LOG_STEPS-2:0], 1'b1};
      end else begin
         d_in_v.m    = p[31:0];
         d_in_v.frac = {d_in.frac[cg2_pkg::LOG_STEPS-2:0], 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         d_ff <= d_in_v;
      end
   end

   assign d_out = d_ff;

endmodule

FILE: src/cg2_sqrt_cell.sv
// cg2_sqrt_cell: one digit step of a 64-bit integer square root.
// Depends on cg2_pkg; idx selects the trial bit 4^(31-idx).
`timescale 1ns / 1ps

module cg2_sqrt_cell (
   input  logic              clock,
   input  logic              en,
   input  logic [4:0]        idx,
   input  cg2_pkg::sqrt_type d_in,
   output cg2_pkg::sqrt_type d_out
);

   cg2_pkg::sqrt_type d_ff, d_in_v;
   logic [5:0]  sh;
   logic [63:0] one_v;
   logic [63:0] trial;

   // Compare and subtract against res + bit
   always_comb begin
      sh    = 6'd62 - {idx, 1'b0};
      one_v = 64'h1 << sh;
      trial = d_in.res + one_v;
      if (d_in.n >= trial) begin
         d_in_v.n   = d_in.n - trial;
         d_in_v.res = (d_in.res >> 1) + one_v;
      end else begin
         d_in_v.n   = d_in.n;
         d_in_v.res = d_in.res >> 1;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         d_ff <= d_in_v;
      end
   end

   assign d_out = d_ff;

endmodule

FILE: src/cg2_cordic_cell.sv
// cg2_cordic_cell: one rotation step of the sine/cosine CORDIC, angle in turns.
// Depends on cg2_pkg (atan table).
`timescale 1ns / 1ps

module cg2_cordic_cell (
   input  logic                clock,
   input  logic                en,
   input  logic [4:0]          idx,
   input  cg2_pkg::cordic_type d_in,
   output cg2_pkg::cordic_type d_out
);

   cg2_pkg::cordic_type d_ff, d_in_v;
   logic signed [33:0] xs, ys, at;

   // Rotate toward zero residual angle
   always_comb begin
      xs = $signed(d_in.x) >>> idx;
      ys = $signed(d_in.y) >>> idx;
      at = $signed({2'b00, cg2_pkg::ATAN_TURNS[idx]});
      d_in_v.neg = d_in.neg;
      if (!d_in.z[33]) begin
         d_in_v.x = d_in.x - ys;
         d_in_v.y = d_in.y + xs;
         d_in_v.z = d_in.z - at;
      end else begin
         d_in_v.x = d_in.x + ys;
         d_in_v.y = d_in.y - xs;
         d_in_v.z = d_in.z + at;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         d_ff <= d_in_v;
      end
   end

   assign d_out = d_ff;

endmodule

FILE: src/cg2_combine.sv
// cg2_combine: mixes radius, sine/cosine and sqrt(1-rho^2) into the scaled,
// offset and saturated x/y pair. Five register stages. Depends on cg2_pkg.
`timescale 1ns / 1ps

module cg2_combine (
   input  logic                clock,
   input  logic                en,
   input  cg2_pkg::cfg_type    cfg,
   input  logic [31:0]         r_in,
   input  logic [30:0]         q_in,
   input  logic signed [33:0]  c_in,
   input  logic signed [33:0]  s_in,
   input  logic [1:0]          status_in,
   output cg2_pkg::result_type res_out
);

   // stage 1
   logic signed [64:0] m1_ff, m1_in;
   logic signed [49:0] m2_ff, m2_in;
   logic [31:0]        r1_ff;
   logic signed [33:0] s1_ff;
   logic [1:0]         st1_ff;
   // stage 2
   logic signed [65:0] sum_a;
   logic signed [35:0] a_ff, a_in;
   logic [31:0]        r2_ff;
   logic signed [33:0] s2_ff;
   logic [1:0]         st2_ff;
   // stage 3
   logic signed [68:0] pa;
   logic signed [66:0] ps;
   logic signed [35:0] px_ff, px_in, py_ff, py_in;
   logic [1:0]         st3_ff;
   // stage 4
   logic signed [68:0] prx, pry;
   logic signed [41:0] dx_ff, dx_in, dy_ff, dy_in;
   logic [1:0]         st4_ff;
   // stage 5
   logic signed [42:0] sx, sy;
   cg2_pkg::result_type out_ff, out_in;

   // q*cos and rho*sin
   always_comb begin
      m1_in = 65'($signed({1'b0, q_in})) * 65'(c_in);
      m2_in = 50'(cfg.rho) * 50'(s_in);
   end

   // A = (q*cos + rho*2^15*sin) >> 30
   always_comb begin
      sum_a = 66'(m1_ff) + (66'(m2_ff) <<< 15);
      a_in  = 36'(sum_a >>> 30);
   end

   // radius times A and sin
   always_comb begin
      pa    = 69'($signed({1'b0, r2_ff})) * 69'(a_ff);
      ps    = 67'($signed({1'b0, r2_ff})) * 67'(s2_ff);
      px_in = 36'(pa >>> 30);
      py_in = 36'(ps >>> 30);
   end

   // sigma scaling
   always_comb begin
      prx   = 69'($signed({1'b0, cfg.sigma_x})) * 69'(px_ff);
      pry   = 69'($signed({1'b0, cfg.sigma_y})) * 69'(py_ff);
      dx_in = 42'(prx >>> 28);
      dy_in = 42'(pry >>> 28);
   end

   // mean offset, saturation, special cases force zero
   always_comb begin
      sx = 43'(cfg.mean_x) + 43'(dx_ff);
      sy = 43'(cfg.mean_y) + 43'(dy_ff);
      out_in.status = st4_ff;
      if (sx > 43'sd2147483647) begin
         out_in.x_out = 32'sh7FFF_FFFF;
      end else if (sx < -43'sd2147483648) begin
         out_in.x_out = 32'sh8000_0000;
      end else begin
         out_in.x_out = sx[31:0];
      end
      if (sy > 43'sd2147483647) begin
         out_in.y_out = 32'sh7FFF_FFFF;
      end else if (sy < -43'sd2147483648) begin
         out_in.y_out = 32'sh8000_0000;
      end else begin
         out_in.y_out = sy[31:0];
      end
      if (st4_ff != cg2_pkg::STATUS_OK) begin
         out_in.x_out = '0;
         out_in.y_out = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         m1_ff  <= m1_in;
         m2_ff  <= m2_in;
         r1_ff  <= r_in;
         s1_ff  <= s_in;
         st1_ff <= status_in;
         a_ff   <= a_in;
         r2_ff  <= r1_ff;
         s2_ff  <= s1_ff;
         st2_ff <= st1_ff;
         px_ff  <= px_in;
         py_ff  <= py_in;
         st3_ff <= st2_ff;
         dx_ff  <= dx_in;
         dy_ff  <= dy_in;
         st4_ff <= st3_ff;
         out_ff <= out_in;
      end
   end

   assign res_out = out_ff;

endmodule

FILE: src/correlated_2d_gaussian_unit.sv
// correlated_2d_gaussian_unit: Box-Muller correlated Gaussian pair generator, top level.
// Uses cg2_pkg, cg2_log_cell, cg2_sqrt_cell, cg2_cordic_cell and cg2_combine.
//
//   channel | ports                                   | direction
//   req     | req_valid/ready, uniform_radius, angle  | in
//   rsp     | rsp_valid/ready, x_out, y_out, status   | out
//   csr     | csr_we, csr_index, csr_wdata            | in (write only)
//
// One item per cycle while the output buffer has room; each item passes the log2 squaring
// cells, the multiply and the 32 square root cells on its way to its result.
// Synchronous active-high reset restores the config register defaults and clears all valid bits.
// The whole pipeline holds only while its two-entry output buffer is full.
`timescale 1ns / 1ps

module correlated_2d_gaussian_unit (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [31:0]        req_uniform_radius,
   input  logic [31:0]        req_uniform_angle,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [31:0] rsp_x_out,
   output logic signed [31:0] rsp_y_out,
   output logic [1:0]         rsp_status,
   input  logic               csr_we,
   input  logic [2:0]         csr_index,
   input  logic [31:0]        csr_wdata
);

   typedef enum logic [2:0] {
      FIFO_EMPTY = 3'b001,
      FIFO_ONE   = 3'b010,
      FIFO_FULL  = 3'b100
   } fifo_state_type;

   cg2_pkg::cfg_type    cfg_ff, cfg_in;
   logic                adv;
   logic [cg2_pkg::PIPE_DEPTH-1:0] vld_ff, vld_in;

   // front stage
   logic [4:0]          k_v;
   cg2_pkg::log_type    lg0_ff, lg0_in;
   cg2_pkg::cordic_type cd0_ff, cd0_in;
   logic [31:0]         rho_sq;
   logic [31:0]         root_arg;
   logic [63:0]         qn0_ff, qn0_in;
   logic signed [33:0]  zs;
   logic [1:0]          st0_in;

   // chains
   cg2_pkg::log_type    lg_chain [cg2_pkg::LOG_STEPS+1];
   cg2_pkg::sqrt_type   sr_chain [cg2_pkg::SQRT_STEPS+1];
   cg2_pkg::sqrt_type   sq_chain [cg2_pkg::SQRT_STEPS+1];
   cg2_pkg::cordic_type cd_chain [cg2_pkg::CORDIC_STEPS+1];
   logic [29:0]         t_v;
   logic [63:0]         w_ff, w_in;
   logic signed [33:0]  c_ff, c_in, s_ff, s_in;

   // alignment lines
   logic signed [33:0]  cdly_ff [cg2_pkg::ANGLE_DLY];
   logic signed [33:0]  sdly_ff [cg2_pkg::ANGLE_DLY];
   logic [30:0]         qdly_ff [cg2_pkg::ROOT_DLY];
   logic [1:0]          stdly_ff [cg2_pkg::RADIUS_LAT];

   // output buffer
   cg2_pkg::result_type comb_res;
   cg2_pkg::result_type head_ff, head_in, skid_ff, skid_in;
   fifo_state_type      fst_ff, fst_in;
   logic                push, pop;

   // Configuration writes
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            cg2_pkg::REG_MEAN_X:  cfg_in.mean_x  = csr_wdata;
            cg2_pkg::REG_MEAN_Y:  cfg_in.mean_y  = csr_wdata;
            cg2_pkg::REG_SIGMA_X: cfg_in.sigma_x = csr_wdata;
            cg2_pkg::REG_SIGMA_Y: cfg_in.sigma_y = csr_wdata;
            cg2_pkg::REG_RHO:     cfg_in.rho     = csr_wdata[15:0];
            default:              cfg_in = cfg_ff;
         endcase
      end
   end

   // Pipeline moves whenever the output buffer has room
   assign adv       = (fst_ff != FIFO_FULL);
   assign req_ready = adv;

   always_comb begin
      vld_in = {vld_ff[cg2_pkg::PIPE_DEPTH-2:0], req_valid};
   end

   // Front stage: normalize u1, fold the angle, form 1 - rho^2, check special cases
   always_comb begin
      k_v = '0;
      for (int i = 0; i < 32; i++) begin
         if (req_uniform_radius[i]) begin
            k_v = 5'(i);
         end
      end
      lg0_in.k    = k_v;
      lg0_in.m    = req_uniform_radius << (5'd31 - k_v);
      lg0_in.frac = '0;

      zs = 34'($signed(req_uniform_angle));
      cd0_in.x   = cg2_pkg::CORDIC_K;
      cd0_in.y   = '0;
      cd0_in.z   = zs;
      cd0_in.neg = 1'b0;
      if (zs > cg2_pkg::QUARTER) begin
         cd0_in.z   = zs - cg2_pkg::HALF_TURN;
         cd0_in.neg = 1'b1;
      end else if (zs < -cg2_pkg::QUARTER) begin
         cd0_in.z   = zs + cg2_pkg::HALF_TURN;
         cd0_in.neg = 1'b1;
      end

      rho_sq   = 32'(cfg_ff.rho * cfg_ff.rho);
      root_arg = cg2_pkg::ONE_Q30 - rho_sq;
      qn0_in   = 64'(root_arg) << 30;

      if (cfg_ff.rho == cg2_pkg::RHO_MINUS1) begin
         st0_in = cg2_pkg::STATUS_RHO;
      end else if (req_uniform_radius == '0) begin
         st0_in = cg2_pkg::STATUS_ZERO;
      end else begin
         st0_in = cg2_pkg::STATUS_OK;
      end
   end

   // Log2 chain
   assign lg_chain[0] = lg0_ff;
   for (genvar gi = 0; gi < cg2_pkg::LOG_STEPS; gi++) begin : g_log
      cg2_log_cell u_cell (
         .clock (clock),
         .en    (adv),
         .d_in  (lg_chain[gi]),
         .d_out (lg_chain[gi+1])
      );
   end

   // -2 ln u1 = 2 * log2(1/u1) * ln 2
   always_comb begin
      t_v  = cg2_pkg::LOG_SPAN -
             {lg_chain[cg2_pkg::LOG_STEPS].k, lg_chain[cg2_pkg::LOG_STEPS].frac};
      w_in = (64'(t_v) * 64'(cg2_pkg::LN2_Q32)) << 1;
   end

   // Radius square root chain
   assign sr_chain[0] = '{n: w_ff, res: 64'd0};
   for (genvar gi = 0; gi < cg2_pkg::SQRT_STEPS; gi++) begin : g_rsqrt
      cg2_sqrt_cell u_cell (
         .clock (clock),
         .en    (adv),
         .idx   (5'(gi)),
         .d_in  (sr_chain[gi]),
         .d_out (sr_chain[gi+1])
      );
   end

   // sqrt(1 - rho^2) chain
   assign sq_chain[0] = '{n: qn0_ff, res: 64'd0};
   for (genvar gi = 0; gi < cg2_pkg::SQRT_STEPS; gi++) begin : g_qsqrt
      cg2_sqrt_cell u_cell (
         .clock (clock),
         .en    (adv),
         .idx   (5'(gi)),
         .d_in  (sq_chain[gi]),
         .d_out (sq_chain[gi+1])
      );
   end

   // CORDIC chain
   assign cd_chain[0] = cd0_ff;
   for (genvar gi = 0; gi < cg2_pkg::CORDIC_STEPS; gi++) begin : g_cordic
      cg2_cordic_cell u_cell (
         .clock (clock),
         .en    (adv),
         .idx   (5'(gi)),
         .d_in  (cd_chain[gi]),
         .d_out (cd_chain[gi+1])
      );
   end

   // Undo the half-turn fold
   always_comb begin
      if (cd_chain[cg2_pkg::CORDIC_STEPS].neg) begin
         c_in = -cd_chain[cg2_pkg::CORDIC_STEPS].x;
         s_in = -cd_chain[cg2_pkg::CORDIC_STEPS].y;
      end else begin
         c_in = cd_chain[cg2_pkg::CORDIC_STEPS].x;
         s_in = cd_chain[cg2_pkg::CORDIC_STEPS].y;
      end
   end

   // Pipeline data registers; q reaches 2^30 at rho zero, so it keeps 31 bits
   always_ff @(posedge clock) begin
      if (adv) begin
         lg0_ff <= lg0_in;
         cd0_ff <= cd0_in;
         qn0_ff <= qn0_in;
         w_ff   <= w_in;
         c_ff   <= c_in;
         s_ff   <= s_in;
         cdly_ff[0]  <= c_ff;
         sdly_ff[0]  <= s_ff;
         qdly_ff[0]  <= sq_chain[cg2_pkg::SQRT_STEPS].res[30:0];
         stdly_ff[0] <= st0_in;
         for (int i = 1; i < cg2_pkg::ANGLE_DLY; i++) begin
            cdly_ff[i] <= cdly_ff[i-1];
            sdly_ff[i] <= sdly_ff[i-1];
         end
         for (int i = 1; i < cg2_pkg::ROOT_DLY; i++) begin
            qdly_ff[i] <= qdly_ff[i-1];
         end
         for (int i = 1; i < cg2_pkg::RADIUS_LAT; i++) begin
            stdly_ff[i] <= stdly_ff[i-1];
         end
      end
   end

   // Final mix
   cg2_combine u_combine (
      .clock     (clock),
      .en        (adv),
      .cfg       (cfg_ff),
      .r_in      (sr_chain[cg2_pkg::SQRT_STEPS].res[31:0]),
      .q_in      (qdly_ff[cg2_pkg::ROOT_DLY-1]),
      .c_in      (cdly_ff[cg2_pkg::ANGLE_DLY-1]),
      .s_in      (sdly_ff[cg2_pkg::ANGLE_DLY-1]),
      .status_in (stdly_ff[cg2_pkg::RADIUS_LAT-1]),
      .res_out   (comb_res)
   );

   // Two-entry output buffer
   assign push = adv && vld_ff[cg2_pkg::PIPE_DEPTH-1];
   assign pop  = rsp_valid && rsp_ready;

   always_comb begin
      fst_in  = fst_ff;
      head_in = head_ff;
      skid_in = skid_ff;
      case (fst_ff)
         FIFO_EMPTY: begin
            if (push) begin
               head_in = comb_res;
               fst_in  = FIFO_ONE;
            end
         end
         FIFO_ONE: begin
            if (push && pop) begin
               head_in = comb_res;
            end else if (push) begin
               skid_in = comb_res;
               fst_in  = FIFO_FULL;
            end else if (pop) begin
               fst_in  = FIFO_EMPTY;
            end
         end
         FIFO_FULL: begin
            if (pop) begin
               head_in = skid_ff;
               fst_in  = FIFO_ONE;
            end
         end
         default: fst_in = FIFO_EMPTY;
      endcase
   end

   always_ff @(posedge clock) begin
      head_ff <= head_in;
      skid_ff <= skid_in;
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '{mean_x: 32'sd0, mean_y: 32'sd0, sigma_x: 32'd65536,
                     sigma_y: 32'd65536, rho: 16'sd0};
         vld_ff <= '0;
         fst_ff <= FIFO_EMPTY;
      end else begin
         cfg_ff <= cfg_in;
         fst_ff <= fst_in;
         if (adv) begin
            vld_ff <= vld_in;
         end
      end
   end

   assign rsp_valid  = (fst_ff != FIFO_EMPTY);
   assign rsp_x_out  = head_ff.x_out;
   assign rsp_y_out  = head_ff.y_out;
   assign rsp_status = head_ff.status;

endmodule

FILE: tb/sv/tb.sv
// tb: self-checking bench for correlated_2d_gaussian_unit (Box-Muller pair generator).
// Depends on cg2_pkg and the unit RTL; predicts each pair in fixed point and checks it.
`timescale 1ns / 1ps

module tb;
   import cg2_pkg::*;

   localparam logic [2:0] REG_UNUSED = 3'd5;
   localparam int         STALL_LEN  = 300;
   localparam int         WD_LIMIT   = 3000;
   localparam int         DRAIN_WAIT = PIPE_DEPTH + 10;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_ready;
   logic [31:0]        req_uniform_radius = '0;
   logic [31:0]        req_uniform_angle = '0;
   logic               rsp_valid;
   logic               rsp_ready = 1'b0;
   logic signed [31:0] rsp_x_out;
   logic signed [31:0] rsp_y_out;
   logic [1:0]         rsp_status;
   logic               csr_we = 1'b0;
   logic [2:0]         csr_index = '0;
   logic [31:0]        csr_wdata = '0;

   cfg_type    cfg_shadow;
   result_type pending_pairs[$];
   int         errors = 0;
   int         pairs_checked = 0;
   int         status_seen[3] = '{0, 0, 0};
   bit         quiet = 1'b0;
   bit         stall_req = 1'b0;
   int         idle_cycles = 0;

   correlated_2d_gaussian_unit dut (.*);

   // clock
   initial begin
      forever #5 clock = ~clock;
   end

   // ---------------- predictor ----------------
   function automatic longint unsigned log2_q24(longint unsigned v);
      int k;
      longint unsigned m, frac;
      k = 31;
      while (k > 0 && v[k] == 1'b0) k--;
      m = v << (31 - k);
      frac = 0;
      for (int i = 0; i < LOG_STEPS; i++) begin
         m = (m * m) >> 31;
         frac = frac << 1;
         if (m >= 64'h1_0000_0000) begin
            frac = frac | 1;
            m = m >> 1;
         end
      end
      return (longint'(k) << LOG_STEPS) | frac;
   endfunction

   function automatic longint unsigned int_sqrt(longint unsigned n);
      longint unsigned res, b;
      res = 0;
      b = 64'h1 << 62;
      while (b > n) b = b >> 2;
      while (b != 0) begin
         if (n >= res + b) begin
            n = n - (res + b);
            res = (res >> 1) + b;
         end else begin
            res = res >> 1;
         end
         b = b >> 2;
      end
      return res;
   endfunction

   // CORDIC rotation, angle in turns, folded into a quarter turn around zero
   task automatic sincos_turns(input logic [31:0] ang, output longint c, output longint s);
      longint z, x, y, nx;
      bit     neg;
      z = longint'(ang);
      if (z >= (64'sd1 <<< 31)) z = z - (64'sd1 <<< 32);
      neg = 1'b0;
      if (z > (64'sd1 <<< 30)) begin
         z = z - (64'sd1 <<< 31);
         neg = 1'b1;
      end else if (z < -(64'sd1 <<< 30)) begin
         z = z + (64'sd1 <<< 31);
         neg = 1'b1;
      end
      x = longint'(CORDIC_K);
      y = 0;
      for (int i = 0; i < CORDIC_STEPS; i++) begin
         if (z >= 0) begin
            nx = x - (y >>> i);
            y  = y + (x >>> i);
            z  = z - longint'(ATAN_TURNS[i]);
         end else begin
            nx = x + (y >>> i);
            y  = y - (x >>> i);
            z  = z + longint'(ATAN_TURNS[i]);
         end
         x = nx;
      end
      c = neg ? -x : x;
      s = neg ? -y : y;
   endtask

   function automatic logic [31:0] clamp32(longint v);
      if (v > 64'sd2147483647) return 32'h7FFF_FFFF;
      if (v < -64'sd2147483648) return 32'h8000_0000;
      return v[31:0];
   endfunction

   task automatic predict_pair(input logic [31:0] ur, input logic [31:0] ua,
                               output result_type res);
      longint          rh, c, s, a, px, py, dx, dy;
      longint unsigned t, w, r, q;
      rh = longint'(cfg_shadow.rho);
      res = '0;
      if (cfg_shadow.rho == RHO_MINUS1) begin
         res.status = STATUS_RHO;
      end else if (ur == 0) begin
         res.status = STATUS_ZERO;
      end else begin
         t = (64'd32 << LOG_STEPS) - log2_q24(longint'(ur));
         w = (t * longint'(LN2_Q32)) << 1;
         r = int_sqrt(w);
         sincos_turns(ua, c, s);
         q = int_sqrt(((64'd1 << 30) - longint'(rh * rh)) << 30);
         a  = (longint'(q) * c + rh * 32768 * s) >>> 30;
         px = (longint'(r) * a) >>> 30;
         py = (longint'(r) * s) >>> 30;
         dx = (longint'(cfg_shadow.sigma_x) * px) >>> 28;
         dy = (longint'(cfg_shadow.sigma_y) * py) >>> 28;
         res.x_out  = clamp32(longint'(cfg_shadow.mean_x) + dx);
         res.y_out  = clamp32(longint'(cfg_shadow.mean_y) + dy);
         res.status = STATUS_OK;
      end
   endtask

   // ---------------- monitors ----------------
   task automatic report_mismatch(input string what);
      errors++;
      $display("MISMATCH @%0t: %s", $time, what);
   endtask

   // expected pair queued on every input transfer
   always @(posedge clock) begin
      result_type e;
      if (!reset && req_valid && req_ready) begin
         predict_pair(req_uniform_radius, req_uniform_angle, e);
         pending_pairs.push_back(e);
      end
   end

   // result transfers compared against the oldest expectation
   always @(posedge clock) begin
      result_type e;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_pairs.size() == 0) begin
            report_mismatch("result with nothing pending");
         end else begin
            e = pending_pairs.pop_front();
            pairs_checked++;
            if (e.status < 3) status_seen[e.status]++;
            if (rsp_status !== e.status)
               report_mismatch($sformatf("status %0d, want %0d", rsp_status, e.status));
            if (rsp_x_out !== e.x_out)
               report_mismatch($sformatf("x_out %h, want %h", rsp_x_out, e.x_out));
            if (rsp_y_out !== e.y_out)
               report_mismatch($sformatf("y_out %h, want %h", rsp_y_out, e.y_out));
         end
      end
   end

   // watchdog on cycles without any transfer
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WD_LIMIT) begin
         $display("tb failed");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // receiver: random stall bursts, one long hold-off on request
   initial begin
      forever begin
         @(negedge clock);
         if (stall_req) begin
            rsp_ready = 1'b0;
            repeat (STALL_LEN) @(negedge clock);
            stall_req = 1'b0;
         end else if (quiet || $urandom_range(0, 3) != 0) begin
            rsp_ready = 1'b1;
            repeat ($urandom_range(0, 15)) begin
               if (!stall_req) @(negedge clock);
            end
         end else begin
            rsp_ready = 1'b0;
            repeat ($urandom_range(0, 9)) @(negedge clock);
         end
      end
   end

   // ---------------- driver ----------------
   // call at a falling edge; returns at the falling edge after the transfer
   task automatic send_sample(input logic [31:0] ur, input logic [31:0] ua);
      if (!quiet && $urandom_range(0, 4) == 0) begin
         req_valid = 1'b0;
         repeat ($urandom_range(1, 10)) @(negedge clock);
      end
      req_valid = 1'b1;
      req_uniform_radius = ur;
      req_uniform_angle = ua;
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
   endtask

   task automatic wait_drained();
      req_valid = 1'b0;
      while (pending_pairs.size() != 0) @(negedge clock);
      repeat (DRAIN_WAIT) @(negedge clock);
   endtask

   // block must be idle when this is called
   task automatic write_reg(input logic [2:0] idx, input logic [31:0] data);
      csr_we = 1'b1;
      csr_index = idx;
      csr_wdata = data;
      @(negedge clock);
      csr_we = 1'b0;
      case (idx)
         REG_MEAN_X:  cfg_shadow.mean_x  = data;
         REG_MEAN_Y:  cfg_shadow.mean_y  = data;
         REG_SIGMA_X: cfg_shadow.sigma_x = data;
         REG_SIGMA_Y: cfg_shadow.sigma_y = data;
         REG_RHO:     cfg_shadow.rho     = data[15:0];
         default: ;
      endcase
   endtask

   task automatic set_config(input logic [31:0] mx, input logic [31:0] my,
                             input logic [31:0] sx, input logic [31:0] sy,
                             input logic [15:0] rh);
      wait_drained();
      write_reg(REG_MEAN_X, mx);
      write_reg(REG_MEAN_Y, my);
      write_reg(REG_SIGMA_X, sx);
      write_reg(REG_SIGMA_Y, sy);
      write_reg(REG_RHO, {16'h0, rh});
   endtask

   function automatic logic [31:0] rand_radius();
      int pick;
      pick = $urandom_range(0, 19);
      if (pick == 0) return 32'h0;
      if (pick < 6) return $urandom >> $urandom_range(0, 31);
      return $urandom;
   endfunction

   function automatic logic [31:0] rand_sigma();
      if ($urandom_range(0, 7) == 0) return $urandom;
      return $urandom >> $urandom_range(12, 31);
   endfunction

   // ---------------- tests ----------------
   task automatic test_corners();
      logic [31:0] radii[5]  = '{32'h1, 32'hFFFF_FFFF, 32'h0, 32'h8000_0000, 32'h0000_0100};
      logic [31:0] angles[4] = '{32'h0, 32'h4000_0000, 32'h8000_0000, 32'hFFFF_FFFF};
      // defaults after reset, radius and angle extremes
      foreach (radii[i]) send_sample(radii[i], angles[i % 4]);
      send_sample(32'h1234_5678, 32'hC000_0000);
      send_sample(32'h7FFF_FFFF, 32'h2000_0000);
      // rho minus one flags status regardless of the codes
      set_config(32'h0001_0000, 32'hFFFF_0000, 32'h0001_0000, 32'h0001_0000, 16'h8000);
      send_sample(32'h0, 32'h0);
      send_sample(32'hFFFF_FFFF, 32'h1111_1111);
      // strongest legal correlations
      set_config(32'h0, 32'h0, 32'h0002_0000, 32'h0000_8000, 16'h7FFF);
      send_sample(32'h0000_0010, 32'h1000_0000);
      send_sample(32'hABCD_0000, 32'hE000_0000);
      set_config(32'h0, 32'h0, 32'h0001_0000, 32'h0001_0000, 16'h8001);
      send_sample(32'h0000_0010, 32'h1000_0000);
      // saturation at both ends
      set_config(32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'h0);
      send_sample(32'h1, 32'h0);
      send_sample(32'h1, 32'h4000_0000);
      send_sample(32'h1, 32'h8000_0000);
      send_sample(32'h1, 32'hC000_0000);
      // zero sigma, and writes to an unused index are dropped
      set_config(32'h0003_0000, 32'hFFFD_0000, 32'h0, 32'h0, 16'h4000);
      write_reg(REG_UNUSED, 32'hFFFF_FFFF);
      write_reg(3'd7, 32'h1234_5678);
      send_sample(32'h1, 32'h3000_0000);
      send_sample(32'h0, 32'h3000_0000);
   endtask

   task automatic test_random_settings(input int phases, input int per_phase);
      logic [15:0] rh;
      for (int p = 0; p < phases; p++) begin
         rh = ($urandom_range(0, 9) == 0) ? 16'h8000 : 16'($urandom);
         set_config($urandom >> $urandom_range(0, 16), $urandom, rand_sigma(),
                    rand_sigma(), rh);
         repeat (per_phase) send_sample(rand_radius(), $urandom);
      end
   endtask

   task automatic test_output_stall();
      set_config(32'h0, 32'h0, 32'h0001_0000, 32'h0001_0000, 16'h2000);
      stall_req = 1'b1;
      repeat (120) send_sample(rand_radius(), $urandom);
   endtask

   task automatic test_drain_pause();
      repeat (40) send_sample(rand_radius(), $urandom);
      req_valid = 1'b0;
      while (pending_pairs.size() != 0) @(negedge clock);
      repeat (40) send_sample(rand_radius(), $urandom);
   endtask

   task automatic test_streaming();
      set_config(32'hFFFF_8000, 32'h0000_4000, 32'h0000_C000, 32'h0003_0000, 16'hA000);
      quiet = 1'b1;
      repeat (300) send_sample(rand_radius(), $urandom);
   endtask

   // ---------------- sequence ----------------
   initial begin
      cfg_shadow = '{mean_x: 32'sd0, mean_y: 32'sd0, sigma_x: 32'd65536,
                     sigma_y: 32'd65536, rho: 16'sd0};
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      test_corners();
      test_random_settings(10, 100);
      test_output_stall();
      test_drain_pause();
      test_streaming();
      req_valid = 1'b0;
      while (pending_pairs.size() != 0) @(negedge clock);
      repeat (DRAIN_WAIT) @(negedge clock);
      if (pending_pairs.size() != 0)
         report_mismatch($sformatf("%0d results never arrived", pending_pairs.size()));
      $display("Checked %0d pairs over corner, random, stall and streaming phases.",
               pairs_checked);
      $display("Status counts: ok %0d, rho invalid %0d, zero radius %0d; mismatches %0d.",
               status_seen[0], status_seen[1], status_seen[2], errors);
      if (errors == 0) begin
         $display("tb passed");
      end else begin
         $display("tb failed");
      end
      $finish;
   end

endmodule
